@@ hdl/bicycle_model_pose_integrator_core_assert.svh @@
// assertion macros shared by the pose integrator rtl
`ifndef BICYCLE_MODEL_POSE_INTEGRATOR_CORE_ASSERT_SVH
`define BICYCLE_MODEL_POSE_INTEGRATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BMPI_ASSERT_IMP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define BMPI_ASSERT_IMP(lbl, clk, rst_n, prop, msg)
`endif

`ifndef SYNTHESIS
`define BMPI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BMPI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ hdl/bmpi_pkg.sv @@
// shared constants, types and tables of the pose integrator
package bmpi_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam int DIV_Q = 48;
    localparam int DIV_CNT_W = 6;

    localparam logic [32:0] TURN_PER_RAD = 33'd683565276;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic signed [17:0] STEER_LIMIT = 18'sd98304;
    localparam logic [19:0] BASE_MIN = 20'd6554;

    localparam logic [2:0] REG_STEP_TIME = 3'd0;
    localparam logic [2:0] REG_WHEEL_BASE = 3'd1;
    localparam logic [2:0] REG_START_X = 3'd2;
    localparam logic [2:0] REG_START_Y = 3'd3;
    localparam logic [2:0] REG_START_HEADING = 3'd4;

    typedef struct packed {
        logic done;
        logic signed [33:0] cos_val;
        logic signed [33:0] sin_val;
    } cordic_res_t;

    typedef struct packed {
        logic done;
        logic neg;
        logic [DIV_Q-1:0] quo;
    } div_res_t;

    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0: r = 32'h20000000;
            5'd1: r = 32'h12E4051E;
            5'd2: r = 32'h09FB385B;
            5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;
            5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;
            5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;
            5'd9: r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            5'd31: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/bicycle_model_pose_integrator_core.sv @@
// top level: kinematic bicycle pose integrator with sequencer and config registers
//
//  channel   dir   fields                                  transaction
//  s_*       in    speed, steer_angle                      tvalid && tready
//  m_*       out   pos_x, pos_y, heading_angle             tvalid && tready
//  apb       in    step_time, wheel_base, start_x/y/hdg    psel && penable && pwrite
//
// each item takes two cordic passes, two divider passes of 48 quotient bits and seven
// passes through the one shared multiplier, then the result goes to the output register
// s_tready is high only while the sequencer is idle
// the result sits in an output register; a stalled m_tready holds the next result
// in the last sequencer step until the register frees up
// reset loads the config defaults and a zero pose, no clearing pass
`include "bicycle_model_pose_integrator_core_assert.svh"

module bicycle_model_pose_integrator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // speed[21:0], steer_angle[39:22]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // pos_x[31:0], pos_y[63:32], heading_angle[95:64]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_MSTEER = 5'd1;
    localparam logic [4:0] ST_MDIST = 5'd2;
    localparam logic [4:0] ST_DISTC = 5'd3;
    localparam logic [4:0] ST_CORD1 = 5'd4;
    localparam logic [4:0] ST_DIV1 = 5'd5;
    localparam logic [4:0] ST_MRAD = 5'd6;
    localparam logic [4:0] ST_DIV2S = 5'd7;
    localparam logic [4:0] ST_DIV2 = 5'd8;
    localparam logic [4:0] ST_MLO = 5'd9;
    localparam logic [4:0] ST_MHI = 5'd10;
    localparam logic [4:0] ST_HEAD = 5'd11;
    localparam logic [4:0] ST_CORD2 = 5'd12;
    localparam logic [4:0] ST_MX = 5'd13;
    localparam logic [4:0] ST_MY = 5'd14;
    localparam logic [4:0] ST_YUP = 5'd15;
    localparam logic [4:0] ST_OUT = 5'd16;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'h7FFFFFFF;
        else if (v < -34'sd2147483648)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    logic [4:0]          state_reg, state_next;
    logic [15:0]         step_time_reg, step_time_next;
    logic [19:0]         wheel_base_reg, wheel_base_next;
    logic [31:0]         start_x_reg, start_x_next;
    logic [31:0]         start_y_reg, start_y_next;
    logic [31:0]         start_heading_reg, start_heading_next;
    logic [31:0]         pose_x_reg, pose_x_next;
    logic [31:0]         pose_y_reg, pose_y_next;
    logic [31:0]         pose_heading_reg, pose_heading_next;
    logic                out_valid_reg, out_valid_next;
    logic [95:0]         out_data_reg, out_data_next;
    logic signed [21:0]  speed_reg, speed_next;
    logic [16:0]         smag_reg, smag_next;
    logic                sneg_reg, sneg_next;
    logic signed [29:0]  dist_reg, dist_next;
    logic signed [32:0]  tq_reg, tq_next;
    logic                rneg_reg, rneg_next;
    logic [46:0]         rmag_reg, rmag_next;
    logic [31:0]         t1_reg, t1_next;
    logic signed [32:0]  cos_reg, cos_next;
    logic signed [32:0]  sin_reg, sin_next;

    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  prod;
    logic                c_start, c_busy;
    logic [31:0]         c_ang;
    bmpi_pkg::cordic_res_t c_res;
    logic                d_start, d_busy;
    logic signed [59:0]  d_num;
    logic [31:0]         d_den;
    bmpi_pkg::div_res_t  d_res;

    logic                cfg_wr;
    logic [2:0]          cfg_idx;
    logic signed [17:0]  st_in, st_cl;
    logic [47:0]         sbam_sum;
    logic [31:0]         sbam_mag, sbam;
    logic [63:0]         lo_sum;
    logic [31:0]         inc_mag, inc;
    logic [31:0]         head_new;
    logic signed [65:0]  rnd;
    logic [19:0]         base;
    logic signed [33:0]  pos_sum;

    bmpi_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    bmpi_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .ang   (c_ang),
        .busy  (c_busy),
        .res   (c_res)
    );

    bmpi_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (d_start),
        .num   (d_num),
        .den   (d_den),
        .busy  (d_busy),
        .res   (d_res)
    );

    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    always_comb
    begin
        unique case (cfg_idx)
            bmpi_pkg::REG_STEP_TIME: prdata = {16'd0, step_time_reg};
            bmpi_pkg::REG_WHEEL_BASE: prdata = {12'd0, wheel_base_reg};
            bmpi_pkg::REG_START_X: prdata = start_x_reg;
            bmpi_pkg::REG_START_Y: prdata = start_y_reg;
            bmpi_pkg::REG_START_HEADING: prdata = start_heading_reg;
            default: prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        st_in = $signed(s_tdata[39:22]);
        if (st_in > bmpi_pkg::STEER_LIMIT)
            st_cl = bmpi_pkg::STEER_LIMIT;
        else if (st_in < -bmpi_pkg::STEER_LIMIT)
            st_cl = -bmpi_pkg::STEER_LIMIT;
        else
            st_cl = st_in;
        base = (wheel_base_reg < bmpi_pkg::BASE_MIN) ? bmpi_pkg::BASE_MIN : wheel_base_reg;

        sbam_sum = prod[47:0] + 48'd32768;
        sbam_mag = sbam_sum[47:16];
        sbam = sneg_reg ? (32'd0 - sbam_mag) : sbam_mag;
        lo_sum = prod[63:0] + 64'h80000000;
        inc_mag = prod[31:0] + t1_reg;
        inc = rneg_reg ? (32'd0 - inc_mag) : inc_mag;
        head_new = pose_heading_reg + inc;
        // round to nearest at bit 38 with floor on the shift
        rnd = prod + 66'sh2000000000;
        pos_sum = 34'($signed(rnd[65:38]));
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        c_start = 1'b0;
        c_ang = sbam;
        d_start = 1'b0;
        d_num = 60'($signed({c_res.sin_val, 24'd0}));
        d_den = (c_res.cos_val < 34'sd1) ? 32'd1 : c_res.cos_val[31:0];

        state_next = state_reg;
        step_time_next = step_time_reg;
        wheel_base_next = wheel_base_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        start_heading_next = start_heading_reg;
        pose_x_next = pose_x_reg;
        pose_y_next = pose_y_reg;
        pose_heading_next = pose_heading_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        speed_next = speed_reg;
        smag_next = smag_reg;
        sneg_next = sneg_reg;
        dist_next = dist_reg;
        tq_next = tq_reg;
        rneg_next = rneg_reg;
        rmag_next = rmag_reg;
        t1_next = t1_reg;
        cos_next = cos_reg;
        sin_next = sin_reg;

        if (m_tready)
            out_valid_next = 1'b0;

        if (cfg_wr)
        begin
            unique case (cfg_idx)
                bmpi_pkg::REG_STEP_TIME: step_time_next = pwdata[15:0];
                bmpi_pkg::REG_WHEEL_BASE: wheel_base_next = pwdata[19:0];
                bmpi_pkg::REG_START_X:
                begin
                    start_x_next = pwdata;
                    pose_x_next = pwdata;
                end
                bmpi_pkg::REG_START_Y:
                begin
                    start_y_next = pwdata;
                    pose_y_next = pwdata;
                end
                bmpi_pkg::REG_START_HEADING:
                begin
                    start_heading_next = pwdata;
                    pose_heading_next = pwdata;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    speed_next = $signed(s_tdata[21:0]);
                    sneg_next = st_cl[17];
                    smag_next = st_cl[17] ? 17'(-st_cl) : st_cl[16:0];
                    state_next = ST_MSTEER;
                end
            end
            ST_MSTEER:
            begin
                mul_a = $signed({16'd0, smag_reg});
                mul_b = $signed(bmpi_pkg::TURN_PER_RAD);
                state_next = ST_MDIST;
            end
            ST_MDIST:
            begin
                mul_a = $signed({17'd0, step_time_reg});
                mul_b = 33'(speed_reg);
                c_start = 1'b1;
                state_next = ST_DISTC;
            end
            ST_DISTC:
            begin
                dist_next = prod[37:8];
                state_next = ST_CORD1;
            end
            ST_CORD1:
            begin
                if (c_res.done)
                begin
                    d_start = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (d_res.done)
                begin
                    tq_next = d_res.neg ? -$signed(d_res.quo[32:0]) : $signed(d_res.quo[32:0]);
                    state_next = ST_MRAD;
                end
            end
            ST_MRAD:
            begin
                mul_a = 33'(dist_reg);
                mul_b = tq_reg;
                state_next = ST_DIV2S;
            end
            ST_DIV2S:
            begin
                d_start = 1'b1;
                d_num = prod[59:0];
                d_den = {12'd0, base};
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                d_num = prod[59:0];
                d_den = {12'd0, base};
                if (d_res.done)
                begin
                    rneg_next = d_res.neg;
                    rmag_next = d_res.quo[46:0];
                    state_next = ST_MLO;
                end
            end
            ST_MLO:
            begin
                mul_a = $signed({1'b0, rmag_reg[31:0]});
                mul_b = $signed(bmpi_pkg::TURN_PER_RAD);
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                mul_a = $signed({18'd0, rmag_reg[46:32]});
                mul_b = $signed(bmpi_pkg::TURN_PER_RAD);
                t1_next = lo_sum[63:32];
                state_next = ST_HEAD;
            end
            ST_HEAD:
            begin
                pose_heading_next = head_new;
                c_ang = head_new;
                c_start = 1'b1;
                state_next = ST_CORD2;
            end
            ST_CORD2:
            begin
                if (c_res.done)
                begin
                    cos_next = c_res.cos_val[32:0];
                    sin_next = c_res.sin_val[32:0];
                    state_next = ST_MX;
                end
            end
            ST_MX:
            begin
                mul_a = 33'(dist_reg);
                mul_b = cos_reg;
                state_next = ST_MY;
            end
            ST_MY:
            begin
                mul_a = 33'(dist_reg);
                mul_b = sin_reg;
                pose_x_next = sat32(34'($signed(pose_x_reg)) + pos_sum);
                state_next = ST_YUP;
            end
            ST_YUP:
            begin
                pose_y_next = sat32(34'($signed(pose_y_reg)) + pos_sum);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {pose_heading_reg, pose_y_reg, pose_x_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_time_reg <= 16'd655;
            wheel_base_reg <= 20'd170394;
            start_x_reg <= 32'd0;
            start_y_reg <= 32'd0;
            start_heading_reg <= 32'd0;
            pose_x_reg <= 32'd0;
            pose_y_reg <= 32'd0;
            pose_heading_reg <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_time_reg <= step_time_next;
            wheel_base_reg <= wheel_base_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            start_heading_reg <= start_heading_next;
            pose_x_reg <= pose_x_next;
            pose_y_reg <= pose_y_next;
            pose_heading_reg <= pose_heading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        speed_reg <= speed_next;
        smag_reg <= smag_next;
        sneg_reg <= sneg_next;
        dist_reg <= dist_next;
        tq_reg <= tq_next;
        rneg_reg <= rneg_next;
        rmag_reg <= rmag_next;
        t1_reg <= t1_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

    `BMPI_ASSERT_IMP(a_accept_blocks, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")
    `BMPI_ASSERT_NEVER(a_units_exclusive, clk, rst_n, c_busy && d_busy, "cordic and divider both busy")
    `BMPI_ASSERT_IMP(a_idle_units, clk, rst_n, (state_reg == ST_IDLE) |-> (!c_busy && !d_busy), "unit busy while idle")
    `BMPI_ASSERT_IMP(a_cordic_done_wait, clk, rst_n, c_res.done |-> (state_reg == ST_CORD1 || state_reg == ST_CORD2), "cordic done outside wait")

endmodule

@@ hdl/bmpi_mul.sv @@
// shared signed multiplier with registered product
module bmpi_mul
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

@@ hdl/bmpi_cordic.sv @@
// iterative rotation-mode cordic, one micro-rotation per cycle
module bmpi_cordic
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          ang,
    output logic                 busy,
    output bmpi_pkg::cordic_res_t res
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [bmpi_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          fold_reg, fold_next;
    logic signed [33:0]            re_reg, re_next;
    logic signed [33:0]            im_reg, im_next;
    logic signed [33:0]            z_reg, z_next;
    logic [31:0]                   a_fold;
    logic signed [33:0]            dre, dim, at;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        fold_next = fold_reg;
        re_next = re_reg;
        im_next = im_reg;
        z_next = z_reg;
        // fold into the right half plane
        a_fold = (ang[31] ^ ang[30]) ? (ang ^ 32'h80000000) : ang;
        dre = im_reg >>> cnt_reg;
        dim = re_reg >>> cnt_reg;
        at = $signed({2'b00, bmpi_pkg::atan_turns(5'(cnt_reg))});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            fold_next = ang[31] ^ ang[30];
            re_next = bmpi_pkg::CORDIC_GAIN;
            im_next = '0;
            z_next = $signed({{2{a_fold[31]}}, a_fold});
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                re_next = re_reg - dre;
                im_next = im_reg + dim;
                z_next = z_reg - at;
            end
            else
            begin
                re_next = re_reg + dre;
                im_next = im_reg - dim;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == bmpi_pkg::CNT_W'(bmpi_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fold_reg <= fold_next;
        re_reg <= re_next;
        im_reg <= im_next;
        z_reg <= z_next;
    end

    assign busy = busy_reg;
    assign res.done = done_reg;
    assign res.cos_val = fold_reg ? -re_reg : re_reg;
    assign res.sin_val = fold_reg ? -im_reg : im_reg;

endmodule

@@ hdl/bmpi_div.sv @@
// iterative restoring divider, signed dividend over positive divisor, one bit per cycle
module bmpi_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [59:0] num,
    input  logic [31:0]        den,
    output logic               busy,
    output bmpi_pkg::div_res_t res
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [bmpi_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                              neg_reg, neg_next;
    logic [31:0]                       den_reg, den_next;
    logic [31:0]                       rem_reg, rem_next;
    logic [bmpi_pkg::DIV_Q-1:0]        sh_reg, sh_next;
    logic [59:0]                       mag;
    logic [32:0]                       t;
    logic                              ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        sh_next = sh_reg;
        mag = num[59] ? 60'(-num) : num;
        t = {rem_reg, sh_reg[bmpi_pkg::DIV_Q-1]};
        ge = t >= {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            neg_next = num[59];
            den_next = den;
            // upper dividend bits stay below the divisor for every operand here
            rem_next = 32'(mag[59:bmpi_pkg::DIV_Q]);
            sh_next = mag[bmpi_pkg::DIV_Q-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(t - {1'b0, den_reg}) : t[31:0];
            sh_next = {sh_reg[bmpi_pkg::DIV_Q-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == bmpi_pkg::DIV_CNT_W'(bmpi_pkg::DIV_Q - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        sh_reg <= sh_next;
    end

    assign busy = busy_reg;
    assign res.done = done_reg;
    assign res.neg = neg_reg;
    assign res.quo = sh_reg;

endmodule

@@ tb/bicycle_model_pose_integrator_core_checker.sv @@
// checker for the pose integrator: predicts each pose update and compares the results
`timescale 1ns / 1ps

module bicycle_model_pose_integrator_core_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // speed[21:0], steer_angle[39:22]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,   // pos_x[31:0], pos_y[63:32], heading_angle[95:64]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          poses_pending,
    output int          motion_count,
    output int          pose_count
);

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading;
    } pose_t;

    localparam longint RAD_TO_BAM = 64'd683565276;
    localparam longint GAIN_Q30 = 64'd652032874;
    localparam logic [31:0] ARCTAN_BAM [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    logic [15:0]        dt_q16;
    logic [19:0]        base_q16;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic [31:0]        cur_heading;
    pose_t              pose_q[$];

    // cos and sin in Q1.30 of a binary angle
    function automatic void cordic_trig(input logic [31:0] ang, output longint co,
                                        output longint si);
        logic   fold;
        logic [31:0] a;
        longint z;
        longint re;
        longint im;
        longint dre;
        longint dim;
        fold = ang[31] ^ ang[30];
        a = fold ? (ang ^ 32'h80000000) : ang;
        z = longint'($signed(a));
        re = GAIN_Q30;
        im = 0;
        for (int i = 0; i < bmpi_pkg::CORDIC_STEPS; i++)
        begin
            dre = im >>> i;
            dim = re >>> i;
            if (z >= 0)
            begin
                re = re - dre;
                im = im + dim;
                z = z - longint'(ARCTAN_BAM[i]);
            end
            else
            begin
                re = re + dre;
                im = im - dim;
                z = z + longint'(ARCTAN_BAM[i]);
            end
        end
        co = fold ? -re : re;
        si = fold ? -im : im;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // advance the pose by one motion transaction
    function automatic pose_t advance_pose(input logic [39:0] motion);
        longint speed;
        longint steer;
        longint smag;
        longint sbam;
        longint co;
        longint si;
        longint tan_q24;
        longint dist_q24;
        longint base;
        logic signed [127:0] wide;
        longint rad;
        longint unsigned rmag;
        longint unsigned inc;
        pose_t p;
        speed = longint'($signed(motion[21:0]));
        steer = longint'($signed(motion[39:22]));
        base = (base_q16 < bmpi_pkg::BASE_MIN) ? longint'(bmpi_pkg::BASE_MIN)
                                                : longint'(base_q16);
        if (steer > longint'(bmpi_pkg::STEER_LIMIT))
            steer = longint'(bmpi_pkg::STEER_LIMIT);
        if (steer < -longint'(bmpi_pkg::STEER_LIMIT))
            steer = -longint'(bmpi_pkg::STEER_LIMIT);
        smag = (steer < 0) ? -steer : steer;
        sbam = (smag * RAD_TO_BAM + 32768) >>> 16;
        if (steer < 0)
            sbam = -sbam;
        cordic_trig(sbam[31:0], co, si);
        if (co < 1)
            co = 1;
        tan_q24 = (si * 64'sd16777216) / co;
        dist_q24 = (longint'(dt_q16) * speed) >>> 8;
        wide = 128'(signed'(dist_q24)) * 128'(signed'(tan_q24));
        wide = wide / 128'(signed'(base));
        rad = wide[63:0];
        rmag = (rad < 0) ? -rad : rad;
        inc = (rmag >> 32) * RAD_TO_BAM
            + (((rmag & 64'hFFFFFFFF) * RAD_TO_BAM + 64'h80000000) >> 32);
        if (rad < 0)
            inc = -inc;
        p.heading = cur_heading + inc[31:0];
        cordic_trig(p.heading, co, si);
        p.pos_x = clip32(longint'(cur_x) + ((dist_q24 * co + 64'sh2000000000) >>> 38));
        p.pos_y = clip32(longint'(cur_y) + ((dist_q24 * si + 64'sh2000000000) >>> 38));
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    assign poses_pending = motion_count - pose_count;

    always @(posedge clk or negedge rst_n)
    begin
        pose_t want;
        pose_t got;
        if (!rst_n)
        begin
            dt_q16 <= 16'd655;
            base_q16 <= 20'd170394;
            cur_x <= '0;
            cur_y <= '0;
            cur_heading <= '0;
            fail_count = 0;
            motion_count <= 0;
            pose_count <= 0;
            pose_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                unique case (paddr[4:2])
                    bmpi_pkg::REG_STEP_TIME:     dt_q16 <= pwdata[15:0];
                    bmpi_pkg::REG_WHEEL_BASE:    base_q16 <= pwdata[19:0];
                    bmpi_pkg::REG_START_X:       cur_x <= pwdata;
                    bmpi_pkg::REG_START_Y:       cur_y <= pwdata;
                    bmpi_pkg::REG_START_HEADING: cur_heading <= pwdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                want = advance_pose(s_tdata);
                pose_q.push_back(want);
                cur_x <= want.pos_x;
                cur_y <= want.pos_y;
                cur_heading <= want.heading;
                motion_count <= motion_count + 1;
            end
            if (m_tvalid && m_tready)
            begin
                pose_count <= pose_count + 1;
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]};
                if (pose_q.size() == 0)
                begin
                    report_mismatch("unexpected pose_x", got.pos_x, 32'd0);
                end
                else
                begin
                    want = pose_q.pop_front();
                    if (got.pos_x !== want.pos_x)
                        report_mismatch("pos_x", got.pos_x, want.pos_x);
                    if (got.pos_y !== want.pos_y)
                        report_mismatch("pos_y", got.pos_y, want.pos_y);
                    if (got.heading !== want.heading)
                        report_mismatch("heading_angle", got.heading, want.heading);
                end
            end
        end
    end

endmodule

@@ tb/tb_bicycle_model_pose_integrator_core.sv @@
// testbench top for the pose integrator: stimulus, register setup and verdict
`timescale 1ns / 1ps

module tb_bicycle_model_pose_integrator_core;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // speed[21:0], steer_angle[39:22]
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;   // pos_x[31:0], pos_y[63:32], heading_angle[95:64]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int poses_pending;
    int motion_count;
    int pose_count;
    int burst_left;
    int reg_writes;
    int cycles;

    bicycle_model_pose_integrator_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bicycle_model_pose_integrator_core_checker pose_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .poses_pending (poses_pending),
        .motion_count  (motion_count),
        .pose_count    (pose_count)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // receiver stall pattern rotates through four characters
    always @(negedge clk)
    begin
        case ((cycles / 512) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ((cycles % 37) > 20);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bicycle_model_pose_integrator_core regression: fail");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        reg_writes++;
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (poses_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_motion(input logic [21:0] speed, input logic [17:0] steer);
        logic taken;
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        s_tdata = {steer, speed};
        s_tvalid = 1'b1;
        do
        begin
            taken = s_tready;
            @(negedge clk);
        end
        while (!taken);
        burst_left--;
    endtask

    function automatic logic [21:0] rand_speed();
        if ($urandom_range(0, 3) == 0)
            return 22'($urandom);
        return 22'(int'($urandom_range(0, 2621440)) - 1310720);
    endfunction

    function automatic logic [17:0] rand_steer();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 18'($urandom);
        if (r < 3)
            return 18'($urandom_range(0, 2000)) - 18'd1000;
        return 18'(int'($urandom_range(0, 196608)) - 98304);
    endfunction

    initial
    begin
        logic [21:0] dir_speed [6];
        logic [17:0] dir_steer [7];
        logic [31:0] dt_val;
        logic [31:0] base_val;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        m_tready = 1'b1;
        burst_left = 0;
        reg_writes = 0;
        cycles = 0;
        dir_speed = '{22'd1310720, -22'sd1310720, 22'h1FFFFF, 22'h200000, 22'd0, 22'd65536};
        dir_steer = '{18'd98304, -18'sd98304, 18'h1FFFF, 18'h20000, 18'd0, 18'd1,
                      18'h3FFFF};
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // extremes of speed and steer at reset defaults, including clamped steer
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 7; j = j + 2 + (i % 2))
                send_motion(dir_speed[i], dir_steer[j]);

        for (int phase = 1; phase <= 8; phase++)
        begin
            wait_idle();
            case (phase)
                1: begin dt_val = 65535; base_val = 6554; end
                2: begin dt_val = 1; base_val = 1048575; end
                3: begin dt_val = 0; base_val = 170394; end
                4: begin dt_val = 32768; base_val = 3; end
                default:
                begin
                    dt_val = $urandom_range(1, 65535);
                    base_val = $urandom_range(6554, 1048575);
                end
            endcase
            write_reg(bmpi_pkg::REG_STEP_TIME, dt_val);
            write_reg(bmpi_pkg::REG_WHEEL_BASE, base_val);
            case (phase)
                1:
                begin
                    write_reg(bmpi_pkg::REG_START_X, 32'h7FFFFF00);
                    write_reg(bmpi_pkg::REG_START_Y, 32'h80000100);
                    write_reg(bmpi_pkg::REG_START_HEADING, 32'h00000000);
                end
                2:
                begin
                    write_reg(bmpi_pkg::REG_START_X, 32'h80000000);
                    write_reg(bmpi_pkg::REG_START_Y, 32'h7FFFFFFF);
                    write_reg(bmpi_pkg::REG_START_HEADING, 32'hFFFFFFFF);
                end
                3:
                begin
                    // writes to unused register slots must be ignored
                    write_reg(3'd5, $urandom);
                    write_reg(3'd7, $urandom);
                end
                default:
                begin
                    write_reg(bmpi_pkg::REG_START_X, $urandom);
                    write_reg(bmpi_pkg::REG_START_Y, $urandom);
                    write_reg(bmpi_pkg::REG_START_HEADING, $urandom);
                end
            endcase
            for (int n = 0; n < 205; n++)
            begin
                if (n == 100)
                    wait_idle();
                send_motion(rand_speed(), rand_steer());
            end
        end

        wait_idle();
        $display("ran %0d motion transactions against %0d pose results", motion_count,
                 pose_count);
        $display("covered %0d register writes over nine settings, idle and stall mixes",
                 reg_writes);
        if (fail_count == 0)
            $display("bicycle_model_pose_integrator_core regression: pass");
        else
            $display("bicycle_model_pose_integrator_core regression: fail");
        $finish;
    end

endmodule

@@ bicycle_model_pose_integrator_core.f @@
+incdir+hdl
hdl/bmpi_pkg.sv
hdl/bmpi_mul.sv
hdl/bmpi_cordic.sv
hdl/bmpi_div.sv
hdl/bicycle_model_pose_integrator_core.sv
tb/bicycle_model_pose_integrator_core_checker.sv
tb/tb_bicycle_model_pose_integrator_core.sv
